// File: hw/rtl/tccw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types, codes and helpers of the text console cell writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam int COL_W    = 7;
	localparam int ROW_W    = 5;
	localparam int ADDR_W   = 11;
	localparam int CELL_W   = 16;
	localparam int S_DATA_W = 128;
	localparam int S_USER_W = 2;
	localparam int M_DATA_W = 32;
	localparam int M_USER_W = 1;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;
	localparam int Q_CNT_W = 3;

	localparam logic [7:0] CH_NEWLINE  = 8'h0a;
	localparam logic [7:0] CH_MINUS    = 8'h2d;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_HEX_BASE = 8'h57;

	typedef enum logic [1:0] {
		OP_CHAR = 2'd0,
		OP_DEC  = 2'd1,
		OP_HEX  = 2'd2,
		OP_POS  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		TK_CURSOR,
		TK_NEWLINE,
		TK_WRITE,
		TK_DROP
	} tkind_t;

	typedef struct packed {
		tkind_t              kind;
		logic [7:0]          ch;
		logic [7:0]          attr;
		logic [ADDR_W-1:0]   addr;
		logic                last;
	} tok_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_CONV,
		F_DIGITS
	} fstate_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		if (d < 4'd10) begin
			return CH_ZERO + {4'h0, d};
		end else begin
			return CH_HEX_BASE + {4'h0, d};
		end
	endfunction

endpackage

// File: hw/rtl/tccw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_front
// Accepts requests, converts numbers to digit characters and queues one
// token per character or newline for the back end.
// ----------------------------------------------------------------------------
module tccw_front #(
	parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [tccw_pkg::S_DATA_W-1:0] s_tdata,
	input  logic [tccw_pkg::S_USER_W-1:0] s_tuser,
	input  logic                          q_full,
	output logic                          push,
	output tccw_pkg::tok_t                push_tok
);
	import tccw_pkg::*;

	fstate_t state_q, state_d;
	logic [4:0]  cnt_q;
	logic        started_q;
	logic [63:0] dig_q;
	logic [31:0] bin_q;
	logic [39:0] bcd_q;
	logic [7:0]  attr_q;

	op_t         op;
	logic [7:0]  char_code;
	logic [31:0] decimal_value;
	logic [63:0] hex_value;
	logic [7:0]  attr_in;
	logic [7:0]  pos_col;
	logic [7:0]  pos_row;
	logic [31:0] magnitude;
	logic        acc;
	logic        pos_ok;
	logic [11:0] pos_addr;
	logic [39:0] bcd_adj;
	logic [39:0] bcd_next;
	logic [3:0]  head_dig;
	logic        emit_dig;

	assign op            = op_t'(s_tuser);
	assign char_code     = s_tdata[7:0];
	assign decimal_value = s_tdata[39:8];
	assign hex_value     = s_tdata[103:40];
	assign attr_in       = {s_tdata[111:108], s_tdata[107:104]};
	assign pos_col       = s_tdata[119:112];
	assign pos_row       = s_tdata[127:120];
	assign magnitude     = decimal_value[31] ? (32'd0 - decimal_value) : decimal_value;
	assign acc           = s_tvalid && s_tready;

	assign pos_ok   = !pos_col[7] && (pos_col < 8'(COLUMNS)) &&
	                  !pos_row[7] && (pos_row < 8'(ROWS));
	assign pos_addr = 12'(pos_row[4:0]) * 12'(COLUMNS) + 12'(pos_col[6:0]);

	always_comb begin
		for (int i = 0; i < 10; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	assign bcd_next = {bcd_adj[38:0], bin_q[31]};
	assign head_dig = dig_q[63:60];
	assign emit_dig = started_q || (head_dig != 4'h0) || (cnt_q == 5'd0);

	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (acc && op == OP_DEC) begin
					state_d = F_CONV;
				end else if (acc && op == OP_HEX) begin
					state_d = F_DIGITS;
				end
			end
			F_CONV: begin
				if (cnt_q == 5'd0) begin
					state_d = F_DIGITS;
				end
			end
			F_DIGITS: begin
				if (!q_full && cnt_q == 5'd0) begin
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		push     = 1'b0;
		push_tok = '{kind: TK_CURSOR, ch: char_code, attr: attr_in,
		             addr: '0, last: 1'b1};
		case (state_q)
			F_IDLE: begin
				s_tready = !q_full;
				case (op)
					OP_CHAR: begin
						push = acc;
						if (char_code == CH_NEWLINE) begin
							push_tok.kind = TK_NEWLINE;
						end
					end
					OP_DEC: begin
						push          = acc && decimal_value[31];
						push_tok.ch   = CH_MINUS;
						push_tok.last = 1'b0;
					end
					OP_POS: begin
						push          = acc;
						push_tok.kind = pos_ok ? TK_WRITE : TK_DROP;
						push_tok.addr = pos_addr[ADDR_W-1:0];
					end
					default: push = 1'b0;
				endcase
			end
			F_DIGITS: begin
				push          = emit_dig && !q_full;
				push_tok.ch   = digit_char(head_dig);
				push_tok.attr = attr_q;
				push_tok.last = (cnt_q == 5'd0);
			end
			default: push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= F_IDLE;
			cnt_q     <= '0;
			started_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				F_IDLE: begin
					if (acc) begin
						cnt_q     <= (op == OP_DEC) ? 5'd31 : 5'd15;
						started_q <= 1'b0;
					end
				end
				F_CONV: begin
					cnt_q <= (cnt_q == 5'd0) ? 5'd9 : cnt_q - 5'd1;
				end
				F_DIGITS: begin
					if (!q_full) begin
						cnt_q     <= cnt_q - 5'd1;
						started_q <= started_q || emit_dig;
					end
				end
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (acc) begin
					attr_q <= attr_in;
					bin_q  <= magnitude;
					bcd_q  <= '0;
					dig_q  <= hex_value;
				end
			end
			F_CONV: begin
				bin_q <= {bin_q[30:0], 1'b0};
				bcd_q <= bcd_next;
				if (cnt_q == 5'd0) begin
					dig_q <= {bcd_next, 24'h0};
				end
			end
			F_DIGITS: begin
				if (!q_full) begin
					dig_q <= {dig_q[59:0], 4'h0};
				end
			end
			default: attr_q <= attr_q;
		endcase
	end

endmodule

// File: hw/rtl/tccw_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_queue
// Small token queue between the front and back ends.
// ----------------------------------------------------------------------------
module tccw_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tccw_pkg::tok_t push_tok,
	input  logic           pop,
	output tccw_pkg::tok_t head,
	output logic           empty,
	output logic           full
);
	import tccw_pkg::*;

	tok_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == Q_CNT_W'(Q_DEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + Q_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - Q_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

endmodule

// File: hw/rtl/tccw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_back
// Moves the cursor for character and newline tokens and produces the cell write results.
// ----------------------------------------------------------------------------
module tccw_back #(
	parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tccw_pkg::tok_t                head,
	input  logic                          empty,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [tccw_pkg::M_DATA_W-1:0] m_tdata,
	output logic [tccw_pkg::M_USER_W-1:0] m_tuser,
	output logic                          m_tlast
);
	import tccw_pkg::*;

	logic [COL_W-1:0]  cursor_col_q;
	logic [ROW_W-1:0]  cursor_row_q;
	logic              m_valid_q;
	logic              we_q;
	logic [ADDR_W-1:0] addr_q;
	logic [CELL_W-1:0] data_q;
	logic              last_q;

	logic              row_open;
	logic [ROW_W-1:0]  row_adv;
	logic [COL_W:0]    col_inc;
	logic              col_wrap;
	logic [11:0]       cur_addr;
	logic [COL_W-1:0]  col_d;
	logic [ROW_W-1:0]  row_d;
	logic              we_d;
	logic [ADDR_W-1:0] addr_d;
	logic [CELL_W-1:0] data_d;

	assign pop      = !empty && (!m_valid_q || m_tready);
	assign row_open = (cursor_row_q < ROW_W'(ROWS));
	assign row_adv  = row_open ? cursor_row_q + ROW_W'(1) : cursor_row_q;
	assign col_inc  = {1'b0, cursor_col_q} + (COL_W+1)'(1);
	assign col_wrap = (col_inc >= (COL_W+1)'(COLUMNS));
	assign cur_addr = 12'(cursor_row_q) * 12'(COLUMNS) + 12'(cursor_col_q);

	always_comb begin
		col_d  = cursor_col_q;
		row_d  = cursor_row_q;
		we_d   = 1'b0;
		addr_d = '0;
		data_d = '0;
		case (head.kind)
			TK_CURSOR: begin
				we_d   = row_open;
				addr_d = row_open ? cur_addr[ADDR_W-1:0] : '0;
				data_d = row_open ? {head.attr, head.ch} : '0;
				if (col_wrap) begin
					col_d = '0;
					row_d = row_adv;
				end else begin
					col_d = col_inc[COL_W-1:0];
				end
			end
			TK_NEWLINE: begin
				col_d = '0;
				row_d = row_adv;
			end
			TK_WRITE: begin
				we_d   = 1'b1;
				addr_d = head.addr;
				data_d = {head.attr, head.ch};
			end
			default: we_d = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_col_q <= '0;
			cursor_row_q <= '0;
			m_valid_q    <= 1'b0;
		end else begin
			if (pop) begin
				cursor_col_q <= col_d;
				cursor_row_q <= row_d;
				m_valid_q    <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			we_q   <= we_d;
			addr_q <= addr_d;
			data_q <= data_d;
			last_q <= head.last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {(M_DATA_W-ADDR_W-CELL_W)'(0), data_q, addr_q};
	assign m_tuser  = we_q;
	assign m_tlast  = last_q;

endmodule

// File: hw/rtl/text_console_cell_writer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cell_writer_core
// Text console writer: characters and numbers at a cursor, or characters at
// a given position, turned into attribute:character cell writes.
//
// Channel   Dir  tdata (low bit up)                         tuser / tlast
// s_        in   char_code, decimal_value, hex_value,       operation
//                foreground, background, pos_col, pos_row
// m_        out  cell_address, cell_data, zero pad          write_enable / last
//
// Hex holds the input while it steps through its digits (one digit per cycle
// while the queue is not full); decimal holds it through the conversion
// (one bit per cycle of the binary to BCD shifter) and then its digits.
// The back end produces one result per cycle while not stalled, from a four
// entry token queue. Reset clears the cursor to the top left cell and empties
// the queue. A stalled output holds its result; the queue then fills and the
// input side stalls.
// ----------------------------------------------------------------------------
module text_console_cell_writer_core #(
	parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// char_code, decimal_value, hex_value, foreground, background, pos_col, pos_row
	input  logic [tccw_pkg::S_DATA_W-1:0] s_tdata,
	// operation
	input  logic [tccw_pkg::S_USER_W-1:0] s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// cell_address, cell_data, zero pad
	output logic [tccw_pkg::M_DATA_W-1:0] m_tdata,
	// write_enable
	output logic [tccw_pkg::M_USER_W-1:0] m_tuser,
	output logic                          m_tlast
);
	import tccw_pkg::*;

	logic push;
	tok_t push_tok;
	logic pop;
	tok_t head;
	logic empty;
	logic full;

	tccw_front #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.q_full  (full),
		.push    (push),
		.push_tok(push_tok)
	);

	tccw_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_tok(push_tok),
		.pop     (pop),
		.head    (head),
		.empty   (empty),
		.full    (full)
	);

	tccw_back #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.empty   (empty),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule

// File: hw/rtl/tccw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_checker
// Port level checks of the text console cell writer, bound to the top level.
// ----------------------------------------------------------------------------
module tccw_checker #(
	parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [tccw_pkg::S_USER_W-1:0] s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [tccw_pkg::M_DATA_W-1:0] m_tdata,
	input logic [tccw_pkg::M_USER_W-1:0] m_tuser,
	input logic                          m_tlast
);
	import tccw_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
		$stable(m_tuser) && $stable(m_tlast))
	else $error("result changed while stalled");

	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0)
	else $error("result without write carries data");

	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> 32'(m_tdata[ADDR_W-1:0]) < COLUMNS * ROWS)
	else $error("cell address beyond screen");

	a_number_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == OP_DEC || s_tuser == OP_HEX)
		|=> !s_tready)
	else $error("request taken while a number is converting");

endmodule

bind text_console_cell_writer_core tccw_checker #(
	.COLUMNS(COLUMNS),
	.ROWS   (ROWS)
) u_tccw_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.m_tlast (m_tlast)
);

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for text_console_cell_writer_core. Drives character,
// decimal, hex and positioned requests, predicts the cell writes from its own
// cursor model and checks every result in order, under varied back pressure.
// ----------------------------------------------------------------------------
module tb;

	import tccw_pkg::*;

	localparam int COLUMNS   = tccw_pkg::COLUMNS_DEF;
	localparam int ROWS      = tccw_pkg::ROWS_DEF;
	localparam int LONG_HOLD = 300;
	localparam int LIMIT     = 400000;
	localparam int SETTLE    = 100;

	typedef struct {
		op_t              op;
		bit [7:0]         ch;
		bit signed [31:0] dec;
		bit [63:0]        hex;
		bit [3:0]         fg;
		bit [3:0]         bg;
		bit signed [7:0]  pcol;
		bit signed [7:0]  prow;
	} console_request_t;

	typedef struct {
		bit        we;
		bit [10:0] addr;
		bit [15:0] data;
		bit        last;
	} cell_write_t;

	class cell_scoreboard;
		bit [COL_W-1:0] col;
		bit [ROW_W-1:0] row;
		cell_write_t    pending[$];
		int             errors;
		int             requests;
		int             results;
		int             writes;
		bit             saturated;

		function void advance_row();
			if (row < ROWS) begin
				row++;
			end
			if (row == ROWS) begin
				saturated = 1'b1;
			end
		endfunction

		function void put_char(bit [7:0] ch, bit [7:0] attr);
			cell_write_t w;
			w.we   = (row < ROWS) && (col < COLUMNS);
			w.addr = w.we ? 11'(row * COLUMNS + col) : '0;
			w.data = w.we ? {attr, ch} : '0;
			w.last = 1'b0;
			pending.push_back(w);
			col++;
			if (col >= COLUMNS) begin
				col = '0;
				advance_row();
			end
		endfunction

		function void note_request(console_request_t r);
			bit [7:0]    attr;
			bit [7:0]    digits[16];
			int          n;
			bit [31:0]   mag;
			bit [63:0]   hv;
			cell_write_t w;
			attr = {r.bg, r.fg};
			w = '{we: 1'b0, addr: '0, data: '0, last: 1'b0};
			n = 0;
			case (r.op)
				OP_CHAR: begin
					if (r.ch == CH_NEWLINE) begin
						col = '0;
						advance_row();
						pending.push_back(w);
					end else begin
						put_char(r.ch, attr);
					end
				end
				OP_DEC: begin
					mag = r.dec;
					if (mag[31]) begin
						put_char(CH_MINUS, attr);
						mag = -mag;
					end
					do begin
						digits[n] = CH_ZERO + 8'(mag % 10);
						mag = mag / 10;
						n++;
					end while (mag != 0);
					while (n > 0) begin
						n--;
						put_char(digits[n], attr);
					end
				end
				OP_HEX: begin
					hv = r.hex;
					do begin
						digits[n] = (hv[3:0] < 4'd10) ? CH_ZERO + 8'(hv[3:0])
							: "a" + 8'(hv[3:0]) - 8'd10;
						hv = hv >> 4;
						n++;
					end while (hv != 0);
					while (n > 0) begin
						n--;
						put_char(digits[n], attr);
					end
				end
				default: begin
					if (r.pcol >= 0 && r.pcol < COLUMNS && r.prow >= 0 && r.prow < ROWS) begin
						w.we   = 1'b1;
						w.addr = 11'(r.prow * COLUMNS + r.pcol);
						w.data = {attr, r.ch};
					end
					pending.push_back(w);
				end
			endcase
			pending[pending.size() - 1].last = 1'b1;
			requests++;
		endfunction

		function void check_result(bit we, bit [10:0] addr, bit [15:0] data, bit last);
			cell_write_t w;
			if (pending.size() == 0) begin
				$error("unexpected result: write_enable %0b cell_address %0d cell_data %h",
					we, addr, data);
				errors++;
				return;
			end
			w = pending.pop_front();
			results++;
			if (w.we) begin
				writes++;
			end
			if (we !== w.we) begin
				$error("write_enable: expected %0b, got %0b", w.we, we);
				errors++;
			end
			if (addr !== w.addr) begin
				$error("cell_address: expected %0d, got %0d", w.addr, addr);
				errors++;
			end
			if (data !== w.data) begin
				$error("cell_data: expected %h, got %h", w.data, data);
				errors++;
			end
			if (last !== w.last) begin
				$error("last: expected %0b, got %0b", w.last, last);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata;
	logic [S_USER_W-1:0]   s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_DATA_W-1:0]   m_tdata;
	logic [M_USER_W-1:0]   m_tuser;
	logic                  m_tlast;

	cell_scoreboard sb = new();
	int             idle_pct;
	int             stall_pct;
	bit             hold_req;
	int             cycles;

	text_console_cell_writer_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	initial cycles = 0;
	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles > LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_result(m_tuser[0], m_tdata[10:0], m_tdata[26:11], m_tlast);
		end
	end

	initial begin
		bit hold_seen;
		int hold_left;
		hold_seen = 1'b0;
		hold_left = 0;
		m_tready  = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	function automatic console_request_t make_request(op_t op, bit [7:0] ch, bit [31:0] dec,
		bit [63:0] hex, int pcol, int prow);
		console_request_t r;
		r.op   = op;
		r.ch   = ch;
		r.dec  = dec;
		r.hex  = hex;
		r.fg   = 4'($urandom);
		r.bg   = 4'($urandom);
		r.pcol = 8'(pcol);
		r.prow = 8'(prow);
		return r;
	endfunction

	function automatic console_request_t random_request();
		console_request_t r;
		int pick;
		pick = $urandom_range(99);
		r = make_request(OP_CHAR, 8'($urandom), $urandom, {$urandom, $urandom},
			$urandom, $urandom);
		if (pick < 5) begin
			r.ch = CH_NEWLINE;
		end else if (pick < 35) begin
			r.op = OP_CHAR;
		end else if (pick < 55) begin
			r.op = OP_DEC;
			if ($urandom_range(1) == 1) begin
				r.dec = $urandom_range(0, 999);
				if ($urandom_range(1) == 1) begin
					r.dec = -r.dec;
				end
			end
		end else if (pick < 75) begin
			r.op  = OP_HEX;
			r.hex = r.hex >> (4 * $urandom_range(0, 16));
		end else begin
			r.op = OP_POS;
			if ($urandom_range(4) != 0) begin
				r.pcol = 8'($urandom_range(0, COLUMNS - 1));
				r.prow = 8'($urandom_range(0, ROWS - 1));
			end
		end
		return r;
	endfunction

	task automatic send_request(console_request_t r);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {r.prow, r.pcol, r.bg, r.fg, r.hex, r.dec, r.ch};
		s_tuser  <= r.op;
		do @(posedge clk); while (!s_tready);
		sb.note_request(r);
	endtask

	task automatic send_random(int count);
		repeat (count) send_request(random_request());
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		idle_pct  = 0;
		stall_pct = 0;
		hold_req  = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(make_request(OP_CHAR, "A", 0, 0, 0, 0));
		send_request(make_request(OP_CHAR, 8'hff, 0, 0, 0, 0));
		send_request(make_request(OP_CHAR, 8'h00, 0, 0, 0, 0));
		send_request(make_request(OP_CHAR, CH_NEWLINE, 0, 0, 0, 0));
		send_request(make_request(OP_DEC, 0, 32'd0, 0, 0, 0));
		send_request(make_request(OP_DEC, 0, 32'hffff_ffff, 0, 0, 0));
		send_request(make_request(OP_DEC, 0, 32'h7fff_ffff, 0, 0, 0));
		send_request(make_request(OP_DEC, 0, 32'h8000_0000, 0, 0, 0));
		send_request(make_request(OP_HEX, 0, 0, 64'd0, 0, 0));
		send_request(make_request(OP_HEX, 0, 0, '1, 0, 0));
		send_request(make_request(OP_HEX, 0, 0, 64'h0123_4567_89ab_cdef, 0, 0));
		send_request(make_request(OP_HEX, 0, 0, '1, 0, 0));
		send_request(make_request(OP_HEX, 0, 0, 64'hfedc_ba98_7654_3210, 0, 0));
		send_request(make_request(OP_POS, "x", 0, 0, 0, 0));
		send_request(make_request(OP_POS, "y", 0, 0, COLUMNS - 1, ROWS - 1));
		send_request(make_request(OP_POS, CH_NEWLINE, 0, 0, 5, 5));
		send_request(make_request(OP_POS, "z", 0, 0, -1, 0));
		send_request(make_request(OP_POS, "z", 0, 0, COLUMNS, 0));
		send_request(make_request(OP_POS, "z", 0, 0, 0, ROWS));
		send_request(make_request(OP_POS, "z", 0, 0, 0, -1));
		send_request(make_request(OP_POS, "z", 0, 0, -128, -128));
		send_request(make_request(OP_POS, "z", 0, 0, 127, 127));
		drain();

		send_random(8);
		hold_req <= ~hold_req;
		send_random(20);
		drain();

		idle_pct = 65;
		send_random(25);
		drain();

		idle_pct  = 0;
		stall_pct = 65;
		send_random(25);
		drain();

		idle_pct  = 33;
		stall_pct = 33;
		send_random(12);
		repeat (ROWS + 1) send_request(make_request(OP_CHAR, CH_NEWLINE, 0, 0, 0, 0));
		send_random(12);
		drain();

		repeat (SETTLE) @(posedge clk);
		$display("Run covered %0d requests and %0d results, %0d of them cell writes,",
			sb.requests, sb.results, sb.writes);
		$display("with all four operations, field extremes and off-screen positions; %s",
			sb.saturated ? "row saturation was reached." : "row saturation was not reached.");
		if (sb.errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
